// ----- hw/rtl/tlc_pkg.sv -----
`timescale 1ns / 1ps

package tlc_pkg;

    localparam int DEF_L1_SETS_MAX    = 256;
    localparam int DEF_L1_WAYS_MAX    = 8;
    localparam int DEF_VB_ENTRIES_MAX = 16;
    localparam int DEF_L2_SETS_MAX    = 1024;
    localparam int DEF_L2_WAYS_MAX    = 16;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 5;

    localparam logic [CFG_AW-1:0] CFG_OFFSET_BITS    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_L1_SET_BITS    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_L1_WAYS        = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_VICTIM_ENTRIES = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_L2_SET_BITS    = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_L2_WAYS        = 3'd5;

    localparam logic [2:0] RST_OFFSET_BITS    = 3'd5;
    localparam logic [3:0] RST_L1_SET_BITS    = 4'd5;
    localparam logic [3:0] RST_L1_WAYS        = 4'd4;
    localparam logic [4:0] RST_VICTIM_ENTRIES = 5'd0;
    localparam logic [3:0] RST_L2_SET_BITS    = 4'd8;
    localparam logic [4:0] RST_L2_WAYS        = 5'd0;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_L1RD,
        S_L1EV,
        S_L2RD,
        S_L2EV,
        S_OUT
    } t_tlc_state;

    typedef struct packed {
        logic accept;
        logic l1_rd;
        logic l1_ev;
        logic l2_rd;
        logic l2_ev;
        logic sel;
        logic clr;
    } t_tlc_cmd;

    typedef struct packed {
        logic cfg_flush;
        logic clr_last;
        logic op0_v;
        logic op1_v;
    } t_tlc_sts;

    typedef struct packed {
        logic        v;
        logic        wr;
        logic [31:0] addr;
    } t_tlc_l2op;

    typedef struct packed {
        logic [1:0] l2_writebacks;
        logic       l2_write_hit;
        logic       l2_write_done;
        logic       l2_read_hit;
        logic       l2_read_done;
        logic       victim_dirty_evict;
        logic       l1_dirty_evict;
        logic       victim_hit;
        logic       l1_hit;
    } t_tlc_res;

endpackage

// ----- hw/rtl/tlc_ram.sv -----
`timescale 1ns / 1ps

module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/tlc_ctrl.sv -----
`timescale 1ns / 1ps

module tlc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_m_tready,
    input  tlc_pkg::t_tlc_sts i_sts,
    output tlc_pkg::t_tlc_cmd o_cmd,
    output logic              o_s_tready,
    output logic              o_m_tvalid
);
    import tlc_pkg::*;

    t_tlc_state r_state, n_state;
    logic       r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        if (i_sts.cfg_flush) begin
            n_state = S_CLR;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (i_sts.clr_last) n_state = S_IDLE;
                end
                S_IDLE: begin
                    if (i_s_tvalid) n_state = S_L1RD;
                end
                S_L1RD: begin
                    n_state = S_L1EV;
                end
                S_L1EV: begin
                    n_state = S_L2RD;
                    n_sel   = 1'b0;
                end
                S_L2RD: begin
                    if (r_sel ? i_sts.op1_v : i_sts.op0_v) n_state = S_L2EV;
                    else n_state = S_OUT;
                end
                S_L2EV: begin
                    if (!r_sel) begin
                        n_state = S_L2RD;
                        n_sel   = 1'b1;
                    end else begin
                        n_state = S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) n_state = S_IDLE;
                end
                default: begin
                    n_state = S_CLR;
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_cmd.sel  = r_sel;
        case (r_state)
            S_CLR:  o_cmd.clr = 1'b1;
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_L1RD: o_cmd.l1_rd = 1'b1;
            S_L1EV: o_cmd.l1_ev = 1'b1;
            S_L2RD: o_cmd.l2_rd = 1'b1;
            S_L2EV: o_cmd.l2_ev = 1'b1;
            S_OUT:  o_m_tvalid = 1'b1;
            default: ;
        endcase
    end

    a_l1_ev_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.l1_ev |-> $past(o_cmd.l1_rd))
        else $error("l1 evaluate without read");

    a_l2_ev_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.l2_ev |-> $past(o_cmd.l2_rd))
        else $error("l2 evaluate without read");

    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_m_tvalid, o_s_tready, o_cmd.clr}))
        else $error("overlapping phases");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && !i_sts.cfg_flush) |=> o_cmd.l1_rd)
        else $error("accepted beat not looked up");

endmodule

// ----- hw/rtl/tlc_dp.sv -----
`timescale 1ns / 1ps

module tlc_dp #(
    parameter int L1_SETS_MAX    = tlc_pkg::DEF_L1_SETS_MAX,
    parameter int L1_WAYS_MAX    = tlc_pkg::DEF_L1_WAYS_MAX,
    parameter int VB_ENTRIES_MAX = tlc_pkg::DEF_VB_ENTRIES_MAX,
    parameter int L2_SETS_MAX    = tlc_pkg::DEF_L2_SETS_MAX,
    parameter int L2_WAYS_MAX    = tlc_pkg::DEF_L2_WAYS_MAX
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tlc_pkg::t_tlc_cmd           i_cmd,
    output tlc_pkg::t_tlc_sts           o_sts,
    input  logic                        i_op,
    input  logic [31:0]                 i_addr,
    input  logic                        i_cfg_wr_en,
    input  logic [tlc_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [tlc_pkg::CFG_DW-1:0]  i_cfg_wdata,
    output tlc_pkg::t_tlc_res           o_res
);
    import tlc_pkg::*;

    localparam int L1_AW = (L1_SETS_MAX > 1) ? $clog2(L1_SETS_MAX) : 1;
    localparam int L1_SB = $clog2(L1_SETS_MAX + 1) - 1;
    localparam int L1_GW = (L1_WAYS_MAX > 1) ? $clog2(L1_WAYS_MAX) : 1;
    localparam int L1_NW = $clog2(L1_WAYS_MAX + 1);
    localparam int L1_VO = L1_WAYS_MAX * 32;
    localparam int L1_DO = L1_WAYS_MAX * 33;
    localparam int L1_AO = L1_WAYS_MAX * 34;
    localparam int L1_RW = L1_WAYS_MAX * (34 + L1_GW);

    localparam int L2_AW = (L2_SETS_MAX > 1) ? $clog2(L2_SETS_MAX) : 1;
    localparam int L2_SB = $clog2(L2_SETS_MAX + 1) - 1;
    localparam int L2_GW = (L2_WAYS_MAX > 1) ? $clog2(L2_WAYS_MAX) : 1;
    localparam int L2_NW = $clog2(L2_WAYS_MAX + 1);
    localparam int L2_VO = L2_WAYS_MAX * 32;
    localparam int L2_DO = L2_WAYS_MAX * 33;
    localparam int L2_AO = L2_WAYS_MAX * 34;
    localparam int L2_RW = L2_WAYS_MAX * (34 + L2_GW);

    localparam int VB_GW = (VB_ENTRIES_MAX > 1) ? $clog2(VB_ENTRIES_MAX) : 1;
    localparam int VB_NW = $clog2(VB_ENTRIES_MAX + 1);

    // configuration
    logic [2:0] r_off;
    logic [3:0] r_s1, r_s2;
    logic [3:0] r_w1;
    logic [4:0] r_ve, r_w2;

    logic [3:0]       g_s1, g_s2;
    logic [L1_NW-1:0] g_w1;
    logic [VB_NW-1:0] g_ve;
    logic [L2_NW-1:0] g_w2;
    logic             l2_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= RST_OFFSET_BITS;
            r_s1  <= RST_L1_SET_BITS;
            r_w1  <= RST_L1_WAYS;
            r_ve  <= RST_VICTIM_ENTRIES;
            r_s2  <= RST_L2_SET_BITS;
            r_w2  <= RST_L2_WAYS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_OFFSET_BITS:    r_off <= i_cfg_wdata[2:0];
                CFG_L1_SET_BITS:    r_s1  <= i_cfg_wdata[3:0];
                CFG_L1_WAYS:        r_w1  <= i_cfg_wdata[3:0];
                CFG_VICTIM_ENTRIES: r_ve  <= i_cfg_wdata[4:0];
                CFG_L2_SET_BITS:    r_s2  <= i_cfg_wdata[3:0];
                CFG_L2_WAYS:        r_w2  <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        g_s1 = (32'(r_s1) > L1_SB) ? 4'(L1_SB) : r_s1;
        g_s2 = (32'(r_s2) > L2_SB) ? 4'(L2_SB) : r_s2;
        if (32'(r_w1) >= L1_WAYS_MAX) g_w1 = L1_NW'(L1_WAYS_MAX);
        else if (r_w1 == 4'd0) g_w1 = L1_NW'(1);
        else g_w1 = L1_NW'(r_w1);
        if (32'(r_ve) >= VB_ENTRIES_MAX) g_ve = VB_NW'(VB_ENTRIES_MAX);
        else g_ve = VB_NW'(r_ve);
        if (32'(r_w2) >= L2_WAYS_MAX) g_w2 = L2_NW'(L2_WAYS_MAX);
        else g_w2 = L2_NW'(r_w2);
    end

    assign l2_on = (g_w2 != '0);

    // accepted beat
    logic        r_op;
    logic [31:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_addr <= i_addr;
        end
    end

    // l1 address split
    logic [4:0]       sh1;
    logic [31:0]      a1_idx32, l1_tag, blk;
    logic [L1_AW-1:0] l1_idx;

    assign sh1      = {2'b0, r_off} + {1'b0, g_s1};
    assign a1_idx32 = (r_addr >> r_off) & ((32'd1 << g_s1) - 32'd1);
    assign l1_idx   = a1_idx32[L1_AW-1:0];
    assign l1_tag   = r_addr >> sh1;
    assign blk      = r_addr >> r_off;

    logic [L1_RW-1:0]       l1_rrow, l1_wrow;
    logic [L1_SETS_MAX-1:0] r_l1_rowv;
    logic                   r_l1_rv_q;

    tlc_ram #(.WIDTH(L1_RW), .DEPTH(L1_SETS_MAX)) u_l1_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.l1_ev),
        .i_waddr (l1_idx),
        .i_wdata (l1_wrow),
        .i_re    (i_cmd.l1_rd),
        .i_raddr (l1_idx),
        .o_rdata (l1_rrow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_l1_rowv <= '0;
            r_l1_rv_q <= 1'b0;
        end else begin
            if (i_cmd.l1_ev) r_l1_rowv[l1_idx] <= 1'b1;
            if (i_cmd.l1_rd) r_l1_rv_q <= r_l1_rowv[l1_idx];
        end
    end

    // l1 row unpack, invalid row reads as freshly flushed
    logic [31:0]      e1_tag [L1_WAYS_MAX];
    logic [L1_WAYS_MAX-1:0] e1_v, e1_d;
    logic [L1_GW-1:0] e1_age [L1_WAYS_MAX];

    always_comb begin
        for (int i = 0; i < L1_WAYS_MAX; i++) begin
            if (r_l1_rv_q) begin
                e1_tag[i] = l1_rrow[i*32 +: 32];
                e1_v[i]   = l1_rrow[L1_VO + i];
                e1_d[i]   = l1_rrow[L1_DO + i];
                e1_age[i] = l1_rrow[L1_AO + i*L1_GW +: L1_GW];
            end else begin
                e1_tag[i] = '0;
                e1_v[i]   = 1'b0;
                e1_d[i]   = 1'b0;
                e1_age[i] = (L1_NW'(i) < g_w1) ?
                            L1_GW'(g_w1 - L1_NW'(i) - L1_NW'(1)) : '0;
            end
        end
    end

    // l1 lookup and victim choice
    logic             hit1, f_lru1;
    logic [L1_GW-1:0] hitw1, lruw1, pos1;
    logic [L1_GW-1:0] t1_age [L1_WAYS_MAX];

    always_comb begin
        hit1   = 1'b0;
        hitw1  = '0;
        f_lru1 = 1'b0;
        lruw1  = '0;
        for (int i = 0; i < L1_WAYS_MAX; i++) begin
            if (!hit1 && (L1_NW'(i) < g_w1) && e1_v[i] && (e1_tag[i] == l1_tag)) begin
                hit1  = 1'b1;
                hitw1 = L1_GW'(i);
            end
            if (!f_lru1 && (L1_NW'(i) < g_w1) &&
                (L1_NW'(e1_age[i]) == g_w1 - L1_NW'(1))) begin
                f_lru1 = 1'b1;
                lruw1  = L1_GW'(i);
            end
        end
        pos1 = hit1 ? hitw1 : lruw1;
        for (int i = 0; i < L1_WAYS_MAX; i++) begin
            if ((L1_NW'(i) < g_w1) && (e1_age[i] < e1_age[pos1])) t1_age[i] = e1_age[i] + 1'b1;
            else t1_age[i] = e1_age[i];
        end
        t1_age[pos1] = '0;
    end

    logic        old_valid, old_dirty;
    logic [31:0] old_blk;

    assign old_valid = e1_v[lruw1];
    assign old_dirty = old_valid & e1_d[lruw1];
    assign old_blk   = ((e1_tag[lruw1] << sh1) | (a1_idx32 << r_off)) >> r_off;

    // victim buffer
    logic [31:0]             r_vb_tag [VB_ENTRIES_MAX];
    logic [VB_ENTRIES_MAX-1:0] r_vb_v, r_vb_d;
    logic [VB_GW-1:0]        r_vb_age [VB_ENTRIES_MAX];
    logic [31:0]             n_vb_tag [VB_ENTRIES_MAX];
    logic [VB_ENTRIES_MAX-1:0] n_vb_v, n_vb_d;
    logic [VB_GW-1:0]        n_vb_age [VB_ENTRIES_MAX];
    logic [VB_GW-1:0]        t_vb_age [VB_ENTRIES_MAX];
    logic                    vhit, f_vlru;
    logic [VB_GW-1:0]        vpos, vlru, vtpos;

    always_comb begin
        vhit   = 1'b0;
        vpos   = '0;
        f_vlru = 1'b0;
        vlru   = '0;
        for (int j = 0; j < VB_ENTRIES_MAX; j++) begin
            if (!vhit && (VB_NW'(j) < g_ve) && r_vb_v[j] && (r_vb_tag[j] == blk)) begin
                vhit = 1'b1;
                vpos = VB_GW'(j);
            end
            if (!f_vlru && (VB_NW'(j) < g_ve) &&
                (VB_NW'(r_vb_age[j]) == g_ve - VB_NW'(1))) begin
                f_vlru = 1'b1;
                vlru   = VB_GW'(j);
            end
        end
        vtpos = vhit ? vpos : vlru;
        for (int j = 0; j < VB_ENTRIES_MAX; j++) begin
            if ((VB_NW'(j) < g_ve) && (r_vb_age[j] < r_vb_age[vtpos]))
                t_vb_age[j] = r_vb_age[j] + 1'b1;
            else
                t_vb_age[j] = r_vb_age[j];
        end
        t_vb_age[vtpos] = '0;
    end

    // l1 evaluation
    logic [31:0]      n1_tag [L1_WAYS_MAX];
    logic [L1_WAYS_MAX-1:0] n1_v, n1_d;
    t_tlc_res         e_res;
    t_tlc_l2op        e_op0, e_op1;
    logic             vwb;

    always_comb begin
        n1_v   = e1_v;
        n1_d   = e1_d;
        for (int i = 0; i < L1_WAYS_MAX; i++) n1_tag[i] = e1_tag[i];
        n_vb_v = r_vb_v;
        n_vb_d = r_vb_d;
        for (int j = 0; j < VB_ENTRIES_MAX; j++) begin
            n_vb_tag[j] = r_vb_tag[j];
            n_vb_age[j] = r_vb_age[j];
        end
        e_res  = '0;
        e_op0  = '0;
        e_op1  = '0;
        vwb    = r_vb_v[vlru] & r_vb_d[vlru];
        if (hit1) begin
            e_res.l1_hit = 1'b1;
            n1_d[hitw1]  = e1_d[hitw1] | r_op;
        end else begin
            e_res.l1_dirty_evict = old_dirty;
            n1_tag[lruw1] = l1_tag;
            n1_v[lruw1]   = 1'b1;
            n1_d[lruw1]   = r_op;
            if (g_ve != '0) begin
                if (vhit) begin
                    e_res.victim_hit = 1'b1;
                    n1_d[lruw1]      = r_op | r_vb_d[vpos];
                    n_vb_tag[vpos]   = old_blk;
                    n_vb_v[vpos]     = old_valid;
                    n_vb_d[vpos]     = old_dirty;
                    for (int j = 0; j < VB_ENTRIES_MAX; j++) n_vb_age[j] = t_vb_age[j];
                end else begin
                    if (l2_on) e_op0 = '{v: 1'b1, wr: 1'b0, addr: blk << r_off};
                    if (old_valid) begin
                        e_res.victim_dirty_evict = vwb;
                        if (vwb && l2_on)
                            e_op1 = '{v: 1'b1, wr: 1'b1, addr: r_vb_tag[vlru] << r_off};
                        n_vb_tag[vlru] = old_blk;
                        n_vb_v[vlru]   = 1'b1;
                        n_vb_d[vlru]   = old_dirty;
                        for (int j = 0; j < VB_ENTRIES_MAX; j++) n_vb_age[j] = t_vb_age[j];
                    end
                end
            end else if (l2_on && old_dirty) begin
                e_op0 = '{v: 1'b1, wr: 1'b1, addr: old_blk << r_off};
                e_op1 = '{v: 1'b1, wr: 1'b0, addr: blk << r_off};
            end else if (l2_on) begin
                e_op0 = '{v: 1'b1, wr: 1'b0, addr: blk << r_off};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < L1_WAYS_MAX; i++) begin
            l1_wrow[i*32 +: 32]               = n1_tag[i];
            l1_wrow[L1_VO + i]                = n1_v[i];
            l1_wrow[L1_DO + i]                = n1_d[i];
            l1_wrow[L1_AO + i*L1_GW +: L1_GW] = t1_age[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_vb_v <= '0;
            r_vb_d <= '0;
            for (int j = 0; j < VB_ENTRIES_MAX; j++) begin
                r_vb_tag[j] <= '0;
                r_vb_age[j] <= (VB_NW'(j) < g_ve) ?
                               VB_GW'(g_ve - VB_NW'(j) - VB_NW'(1)) : '0;
            end
        end else if (i_cmd.l1_ev) begin
            r_vb_v <= n_vb_v;
            r_vb_d <= n_vb_d;
            for (int j = 0; j < VB_ENTRIES_MAX; j++) begin
                r_vb_tag[j] <= n_vb_tag[j];
                r_vb_age[j] <= n_vb_age[j];
            end
        end
    end

    // l2 access
    t_tlc_l2op r_op0, r_op1, l2op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op0 <= '0;
            r_op1 <= '0;
        end else if (i_cmd.l1_ev) begin
            r_op0 <= e_op0;
            r_op1 <= e_op1;
        end
    end

    assign l2op = i_cmd.sel ? r_op1 : r_op0;

    logic [4:0]       sh2;
    logic [31:0]      a2_idx32, l2_tag;
    logic [L2_AW-1:0] l2_idx, r_clr_cnt;
    logic [L2_RW-1:0] l2_rrow, l2_nrow, l2_irow, l2_wrow;

    assign sh2      = {2'b0, r_off} + {1'b0, g_s2};
    assign a2_idx32 = (l2op.addr >> r_off) & ((32'd1 << g_s2) - 32'd1);
    assign l2_idx   = a2_idx32[L2_AW-1:0];
    assign l2_tag   = l2op.addr >> sh2;
    assign l2_wrow  = i_cmd.clr ? l2_irow : l2_nrow;

    tlc_ram #(.WIDTH(L2_RW), .DEPTH(L2_SETS_MAX)) u_l2_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr | i_cmd.l2_ev),
        .i_waddr (i_cmd.clr ? r_clr_cnt : l2_idx),
        .i_wdata (l2_wrow),
        .i_re    (i_cmd.l2_rd),
        .i_raddr (l2_idx),
        .o_rdata (l2_rrow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_sts.cfg_flush) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    logic [31:0]      e2_tag [L2_WAYS_MAX];
    logic [L2_WAYS_MAX-1:0] e2_v, e2_d, n2_v, n2_d;
    logic [L2_GW-1:0] e2_age [L2_WAYS_MAX];
    logic [L2_GW-1:0] t2_age [L2_WAYS_MAX];
    logic             hit2, f_lru2, wb_inc;
    logic [L2_GW-1:0] hitw2, lruw2, pos2;

    always_comb begin
        hit2   = 1'b0;
        hitw2  = '0;
        f_lru2 = 1'b0;
        lruw2  = '0;
        for (int i = 0; i < L2_WAYS_MAX; i++) begin
            e2_tag[i] = l2_rrow[i*32 +: 32];
            e2_v[i]   = l2_rrow[L2_VO + i];
            e2_d[i]   = l2_rrow[L2_DO + i];
            e2_age[i] = l2_rrow[L2_AO + i*L2_GW +: L2_GW];
        end
        for (int i = 0; i < L2_WAYS_MAX; i++) begin
            if (!hit2 && (L2_NW'(i) < g_w2) && e2_v[i] && (e2_tag[i] == l2_tag)) begin
                hit2  = 1'b1;
                hitw2 = L2_GW'(i);
            end
            if (!f_lru2 && (L2_NW'(i) < g_w2) &&
                (L2_NW'(e2_age[i]) == g_w2 - L2_NW'(1))) begin
                f_lru2 = 1'b1;
                lruw2  = L2_GW'(i);
            end
        end
        pos2 = hit2 ? hitw2 : lruw2;
        for (int i = 0; i < L2_WAYS_MAX; i++) begin
            if ((L2_NW'(i) < g_w2) && (e2_age[i] < e2_age[pos2])) t2_age[i] = e2_age[i] + 1'b1;
            else t2_age[i] = e2_age[i];
        end
        t2_age[pos2] = '0;
        wb_inc = !hit2 && e2_v[lruw2] && e2_d[lruw2];
        n2_v   = e2_v;
        n2_d   = e2_d;
        l2_nrow = '0;
        for (int i = 0; i < L2_WAYS_MAX; i++) l2_nrow[i*32 +: 32] = e2_tag[i];
        if (hit2) begin
            n2_d[hitw2] = e2_d[hitw2] | l2op.wr;
        end else begin
            l2_nrow[lruw2*32 +: 32] = l2_tag;
            n2_v[lruw2] = 1'b1;
            n2_d[lruw2] = l2op.wr;
        end
        for (int i = 0; i < L2_WAYS_MAX; i++) begin
            l2_nrow[L2_VO + i]                = n2_v[i];
            l2_nrow[L2_DO + i]                = n2_d[i];
            l2_nrow[L2_AO + i*L2_GW +: L2_GW] = t2_age[i];
        end
    end

    always_comb begin
        l2_irow = '0;
        for (int i = 0; i < L2_WAYS_MAX; i++) begin
            l2_irow[L2_AO + i*L2_GW +: L2_GW] = (L2_NW'(i) < g_w2) ?
                L2_GW'(g_w2 - L2_NW'(i) - L2_NW'(1)) : '0;
        end
    end

    // result
    t_tlc_res r_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.l1_ev) begin
            r_res <= e_res;
        end else if (i_cmd.l2_ev) begin
            if (l2op.wr) begin
                r_res.l2_write_done <= 1'b1;
                r_res.l2_write_hit  <= hit2;
            end else begin
                r_res.l2_read_done <= 1'b1;
                r_res.l2_read_hit  <= hit2;
            end
            r_res.l2_writebacks <= r_res.l2_writebacks + {1'b0, wb_inc};
        end
    end

    assign o_res = r_res;

    assign o_sts.cfg_flush = i_cfg_wr_en && (i_cfg_addr <= CFG_L2_WAYS);
    assign o_sts.clr_last  = (r_clr_cnt == L2_AW'(L2_SETS_MAX - 1));
    assign o_sts.op0_v     = r_op0.v;
    assign o_sts.op1_v     = r_op1.v;

endmodule

// ----- hw/rtl/two_level_cache_with_victim_buffer.sv -----
`timescale 1ns / 1ps

// Two-level write-back, write-allocate cache tag directory with an optional
// victim buffer. Each input beat is one read (tuser 0) or write (tuser 1) of a
// 32-bit byte address; each gives one result beat of hit, swap and writeback
// flags. One access runs at a time: the L1 tag row is read and then updated,
// then the L2 tag row for the first L2 access is read and, if that access is
// needed, updated; after that update a further L2 read follows, and a further
// update if a second L2 access is needed. The L1 and L2 tag memories are thus
// updated by read-modify-write. Once each result beat is taken the block
// returns to idle before the next input beat is accepted. Any write to a
// configuration register index 0 to 5 flushes all directories without
// writebacks; after reset and after each such write a clearing pass over the
// L2 tag memory runs, during which no beat is accepted. Configuration must be
// written only while no access is in flight; the block itself does not
// enforce this.
module two_level_cache_with_victim_buffer #(
    parameter int L1_SETS_MAX    = tlc_pkg::DEF_L1_SETS_MAX,
    parameter int L1_WAYS_MAX    = tlc_pkg::DEF_L1_WAYS_MAX,
    parameter int VB_ENTRIES_MAX = tlc_pkg::DEF_VB_ENTRIES_MAX,
    parameter int L2_SETS_MAX    = tlc_pkg::DEF_L2_SETS_MAX,
    parameter int L2_WAYS_MAX    = tlc_pkg::DEF_L2_WAYS_MAX
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [31:0]                i_s_axis_tdata,  // addr
    input  logic                       i_s_axis_tuser,  // op
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // l1_hit, victim_hit, l1_dirty_evict, victim_dirty_evict, l2_read_done,
    // l2_read_hit, l2_write_done, l2_write_hit, l2_writebacks[1:0], zero pad
    output logic [15:0]                o_m_axis_tdata,
    input  logic                       i_cfg_wr_en,
    input  logic [tlc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tlc_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import tlc_pkg::*;

    t_tlc_cmd cmd;
    t_tlc_sts sts;
    t_tlc_res res;

    tlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid)
    );

    tlc_dp #(
        .L1_SETS_MAX    (L1_SETS_MAX),
        .L1_WAYS_MAX    (L1_WAYS_MAX),
        .VB_ENTRIES_MAX (VB_ENTRIES_MAX),
        .L2_SETS_MAX    (L2_SETS_MAX),
        .L2_WAYS_MAX    (L2_WAYS_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_s_axis_tuser),
        .i_addr      (i_s_axis_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {6'd0, res};

endmodule

// ----- tb/sv/tlc_outcome_checker.sv -----
`timescale 1ns / 1ps

module tlc_outcome_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [tlc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [tlc_pkg::CFG_DW-1:0] i_cfg_wdata,
    output int          o_fails,
    output int          o_pending
);
    import tlc_pkg::*;

    // flat directory: l1 rows of 8 ways, then victim slots, then l2 rows of 16 ways
    localparam int VB_BASE = 256 * 8;
    localparam int L2_BASE = VB_BASE + 16;
    localparam int N_LINES = L2_BASE + 1024 * 16;

    logic [2:0] off_r;
    logic [3:0] l1_sb_r;
    logic [3:0] l1_w_r;
    logic [4:0] vb_n_r;
    logic [3:0] l2_sb_r;
    logic [4:0] l2_w_r;

    logic [31:0] line_tag[N_LINES];
    bit          line_vld[N_LINES];
    bit          line_dty[N_LINES];
    int          line_age[N_LINES];

    t_tlc_res outcome_q[$];

    function automatic int clamp(int v, int hi);
        return v > hi ? hi : v;
    endfunction

    function automatic int l1_ways_used();
        int w;
        w = clamp(l1_w_r, 8);
        return w == 0 ? 1 : w;
    endfunction

    task automatic set_ages(input int base, input int n, input int span);
        for (int i = 0; i < span; i++) line_age[base + i] = i < n ? n - 1 - i : 0;
    endtask

    task automatic flush_dirs();
        for (int i = 0; i < N_LINES; i++) begin
            line_tag[i] = '0;
            line_vld[i] = 0;
            line_dty[i] = 0;
        end
        for (int s = 0; s < 256; s++) set_ages(s * 8, l1_ways_used(), 8);
        set_ages(VB_BASE, clamp(vb_n_r, 16), 16);
        for (int s = 0; s < 1024; s++) set_ages(L2_BASE + s * 16, clamp(l2_w_r, 16), 16);
    endtask

    task automatic touch(input int base, input int n, input int pos);
        int c;
        c = line_age[base + pos];
        for (int i = 0; i < n; i++) if (line_age[base + i] < c) line_age[base + i]++;
        line_age[base + pos] = 0;
    endtask

    function automatic int oldest(input int base, input int n);
        for (int i = 0; i < n; i++) if (line_age[base + i] == n - 1) return i;
        return 0;
    endfunction

    task automatic l2_lookup(input logic [31:0] a, input bit wr, inout int wbs, output bit hit);
        int o, s2, w2, base, x;
        logic [31:0] tag;
        o = off_r;
        s2 = clamp(l2_sb_r, 10);
        w2 = clamp(l2_w_r, 16);
        base = L2_BASE + 16 * int'((a >> o) & ((32'd1 << s2) - 1));
        tag = a >> (o + s2);
        hit = 0;
        for (int i = 0; i < w2; i++) begin
            if (!hit && line_vld[base + i] && line_tag[base + i] == tag) begin
                hit = 1;
                if (wr) line_dty[base + i] = 1;
                touch(base, w2, i);
            end
        end
        if (!hit) begin
            x = oldest(base, w2);
            if (line_vld[base + x] && line_dty[base + x]) wbs++;
            line_tag[base + x] = tag;
            line_vld[base + x] = 1;
            line_dty[base + x] = wr;
            touch(base, w2, x);
        end
    endtask

    task automatic predict_access(input bit wr, input logic [31:0] addr, output t_tlc_res r);
        int o, s1, w1, ve, base, x, v, wbs;
        bit l2, ov, od, vd, h, found;
        logic [31:0] idx, tag, blk, ob;
        r = '0;
        wbs = 0;
        o = off_r;
        s1 = clamp(l1_sb_r, 8);
        w1 = l1_ways_used();
        ve = clamp(vb_n_r, 16);
        l2 = clamp(l2_w_r, 16) != 0;
        idx = (addr >> o) & ((32'd1 << s1) - 1);
        tag = addr >> (o + s1);
        blk = addr >> o;
        base = 8 * int'(idx);
        found = 0;
        for (int i = 0; i < w1; i++) begin
            if (!found && line_vld[base + i] && line_tag[base + i] == tag) begin
                found = 1;
                if (wr) line_dty[base + i] = 1;
                touch(base, w1, i);
                r.l1_hit = 1;
            end
        end
        if (!found) begin
            x = base + oldest(base, w1);
            ov = line_vld[x];
            od = ov && line_dty[x];
            ob = ((line_tag[x] << (s1 + o)) | (idx << o)) >> o;
            r.l1_dirty_evict = od;
            if (ve > 0) begin
                v = -1;
                for (int j = 0; j < ve; j++)
                    if (v < 0 && line_vld[VB_BASE + j] && line_tag[VB_BASE + j] == blk) v = j;
                if (v >= 0) begin
                    vd = line_dty[VB_BASE + v];
                    touch(VB_BASE, ve, v);
                    line_tag[VB_BASE + v] = ob;
                    line_vld[VB_BASE + v] = ov;
                    line_dty[VB_BASE + v] = od;
                    line_dty[x] = wr || vd;
                    r.victim_hit = 1;
                end else begin
                    if (l2) begin
                        r.l2_read_done = 1;
                        l2_lookup(blk << o, 0, wbs, h);
                        r.l2_read_hit = h;
                    end
                    if (ov) begin
                        v = oldest(VB_BASE, ve);
                        if (line_vld[VB_BASE + v] && line_dty[VB_BASE + v]) begin
                            r.victim_dirty_evict = 1;
                            if (l2) begin
                                r.l2_write_done = 1;
                                l2_lookup(line_tag[VB_BASE + v] << o, 1, wbs, h);
                                r.l2_write_hit = h;
                            end
                        end
                        line_tag[VB_BASE + v] = ob;
                        line_vld[VB_BASE + v] = 1;
                        line_dty[VB_BASE + v] = od;
                        touch(VB_BASE, ve, v);
                    end
                    line_dty[x] = wr;
                end
            end else begin
                if (od && l2) begin
                    r.l2_write_done = 1;
                    l2_lookup(ob << o, 1, wbs, h);
                    r.l2_write_hit = h;
                end
                if (l2) begin
                    r.l2_read_done = 1;
                    l2_lookup(blk << o, 0, wbs, h);
                    r.l2_read_hit = h;
                end
                line_dty[x] = wr;
            end
            line_tag[x] = tag;
            line_vld[x] = 1;
            touch(base, w1, x - base);
        end
        r.l2_writebacks = wbs[1:0];
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            o_fails++;
        end
    endtask

    initial o_fails = 0;
    initial o_pending = 0;

    // sample at the falling edge: these values hold at the next rising edge
    always @(negedge i_clk) begin
        t_tlc_res e;
        t_tlc_res a;
        if (!i_rst_n) begin
            off_r = RST_OFFSET_BITS;
            l1_sb_r = RST_L1_SET_BITS;
            l1_w_r = RST_L1_WAYS;
            vb_n_r = RST_VICTIM_ENTRIES;
            l2_sb_r = RST_L2_SET_BITS;
            l2_w_r = RST_L2_WAYS;
            flush_dirs();
            outcome_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_OFFSET_BITS:    off_r = i_cfg_wdata[2:0];
                    CFG_L1_SET_BITS:    l1_sb_r = i_cfg_wdata[3:0];
                    CFG_L1_WAYS:        l1_w_r = i_cfg_wdata[3:0];
                    CFG_VICTIM_ENTRIES: vb_n_r = i_cfg_wdata;
                    CFG_L2_SET_BITS:    l2_sb_r = i_cfg_wdata[3:0];
                    CFG_L2_WAYS:        l2_w_r = i_cfg_wdata;
                    default: ;
                endcase
                if (i_cfg_addr <= CFG_L2_WAYS) flush_dirs();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_access(i_s_tuser, i_s_tdata, e);
                outcome_q.push_back(e);
            end
            if (i_m_tvalid && i_m_tready) begin
                a = t_tlc_res'(i_m_tdata[9:0]);
                if (outcome_q.size() == 0) begin
                    $error("result beat with no access outstanding: %h", i_m_tdata);
                    o_fails++;
                end else begin
                    e = outcome_q.pop_front();
                    check_field("l1_hit", e.l1_hit, a.l1_hit);
                    check_field("victim_hit", e.victim_hit, a.victim_hit);
                    check_field("l1_dirty_evict", e.l1_dirty_evict, a.l1_dirty_evict);
                    check_field("victim_dirty_evict", e.victim_dirty_evict,
                                a.victim_dirty_evict);
                    check_field("l2_read_done", e.l2_read_done, a.l2_read_done);
                    check_field("l2_read_hit", e.l2_read_hit, a.l2_read_hit);
                    check_field("l2_write_done", e.l2_write_done, a.l2_write_done);
                    check_field("l2_write_hit", e.l2_write_hit, a.l2_write_hit);
                    check_field("l2_writebacks", e.l2_writebacks, a.l2_writebacks);
                    check_field("pad", 0, i_m_tdata[15:10]);
                end
            end
        end
        o_pending = outcome_q.size();
    end
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tlc_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tready = 0;
    logic        cfg_en = 0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        rdy_seen = 0;
    int          fails;
    int          pending;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          quiet_cycles = 0;
    logic [31:0] hi_pool[6];
    logic [31:0] lo_pool[3];

    two_level_cache_with_victim_buffer u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    tlc_outcome_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_cfg_wr_en (cfg_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .o_fails     (fails),
        .o_pending   (pending)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(negedge i_clk) begin
        rdy_seen <= s_tready;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_en || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("two_level_cache_with_victim_buffer verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) m_tready <= $urandom_range(0, 99) >= recv_stall;

    task automatic send_beat(input bit op, input logic [31:0] a);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= a;
        @(posedge i_clk);
        while (!rdy_seen) @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // offset, l1 set bits, l1 ways, victim entries, l2 set bits, l2 ways
    task automatic set_geometry(input int g[6]);
        for (int i = 0; i < 6; i++) begin
            cfg_en <= 1;
            cfg_addr <= CFG_AW'(i);
            cfg_wdata <= CFG_DW'(g[i]);
            @(posedge i_clk);
        end
        cfg_en <= 0;
    endtask

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 99) < 25) return $urandom;
        return hi_pool[$urandom_range(0, 5)] | lo_pool[$urandom_range(0, 2)]
               | ($urandom & 32'h3f);
    endfunction

    initial begin
        int geo[8][6];
        geo = '{'{2, 1, 1, 2, 1, 1}, '{0, 0, 1, 1, 0, 1}, '{7, 15, 15, 31, 15, 31},
                '{2, 2, 2, 4, 3, 4}, '{4, 1, 0, 16, 2, 16}, '{5, 8, 8, 0, 10, 2},
                '{3, 3, 2, 2, 4, 0}, '{0, 0, 0, 0, 0, 0}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // reset geometry: no victim buffer, no l2
        send_beat(1, 32'h0000_0000);
        send_beat(0, 32'h0000_0000);
        send_beat(0, 32'hffff_ffff);
        for (int k = 1; k <= 5; k++) send_beat(1, k << 10);
        drain();

        // tiny geometry: dirty eviction, victim swap, victim writeback to l2
        set_geometry(geo[0]);
        send_beat(1, 32'h0000_0000);
        send_beat(0, 32'h0000_0001);
        send_beat(1, 32'h0000_0008);
        send_beat(0, 32'h0000_0000);
        send_beat(1, 32'h0000_0010);
        send_beat(0, 32'h0000_0018);
        send_beat(0, 32'h0000_0020);
        send_beat(0, 32'h0000_0008);
        send_beat(1, 32'hffff_fffc);
        send_beat(0, 32'h8000_0000);
        send_beat(0, 32'hffff_ffff);
        send_beat(1, 32'h7fff_fff8);
        drain();

        // index outside the register range
        cfg_en <= 1;
        cfg_addr <= CFG_AW'(7);
        cfg_wdata <= 5'h1f;
        @(posedge i_clk);
        cfg_en <= 0;

        for (int p = 1; p < 8; p++) begin
            if (p == 7) for (int i = 0; i < 6; i++) geo[7][i] = $urandom_range(0, 31);
            set_geometry(geo[p]);
            case (p % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 74; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 74; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            for (int i = 0; i < 6; i++) hi_pool[i] = $urandom & 32'hffff_0000;
            for (int i = 0; i < 3; i++) lo_pool[i] = $urandom & 32'h0000_ffc0;
            for (int n = 0; n < 135; n++) begin
                if (n == 90) begin send_idle = 0; recv_stall = 0; end
                send_beat($urandom_range(0, 1), pick_addr());
            end
            drain();
        end

        if (fails == 0)
            $display("two_level_cache_with_victim_buffer verification clean");
        else
            $display("two_level_cache_with_victim_buffer verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/tlc_pkg.sv
hw/rtl/tlc_ram.sv
hw/rtl/tlc_ctrl.sv
hw/rtl/tlc_dp.sv
hw/rtl/two_level_cache_with_victim_buffer.sv
tb/sv/tlc_outcome_checker.sv
tb/sv/testbench.sv
